// ===== rtl/best_route_source_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Route source table assertion macros
// Shared concurrent assertion forms for the route source table.
// ----------------------------------------------------------------------------
`ifndef BEST_ROUTE_SOURCE_TABLE_UNIT_MACROS_SVH
`define BEST_ROUTE_SOURCE_TABLE_UNIT_MACROS_SVH

// Condition must hold in the same cycle as the trigger
`define BRST_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger
`define BRST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/brst_pkg.sv =====
// ----------------------------------------------------------------------------
// Route source table package
// Operation codes, status codes and transaction payload types.
// ----------------------------------------------------------------------------
package brst_pkg;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_LOOKUP  = 2'd2,
        OP_COMPARE = 2'd3
    } op_t;

    // Response status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Request payload
    typedef struct packed {
        op_t         operation;
        logic [15:0] client_id;
        logic [7:0]  admin_distance;
        logic [15:0] next_hop_group;
    } req_t;

    // Response payload
    typedef struct packed {
        logic        status;
        logic        found;
        logic [7:0]  entry_distance;
        logic [15:0] entry_group;
        logic        same;
        logic        best_valid;
        logic [15:0] best_client;
        logic [7:0]  best_distance;
        logic [15:0] best_group;
    } rsp_t;

    // One stored table entry
    typedef struct packed {
        logic [15:0] client;
        logic [7:0]  distance;
        logic [15:0] group;
    } entry_t;

endpackage

// ===== rtl/brst_req_if.sv =====
// ----------------------------------------------------------------------------
// Route source table request channel
// Valid/ready channel carrying one table operation per transaction.
// ----------------------------------------------------------------------------
interface brst_req_if;
    import brst_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/brst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Route source table response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface brst_rsp_if;
    import brst_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/best_route_source_table_unit.sv =====
// ----------------------------------------------------------------------------
// Best route source table
// Client-keyed table of admin distance / next-hop group entries that tracks
// the preferred route source.
// ----------------------------------------------------------------------------
// Requests are handled one at a time: after acceptance no new request is
// taken until the block is back in its idle state. Every operation sweeps
// all slots through the single read port of the entry memory, one slot per
// cycle, each read registered before its slot is compared, then commits the
// write-back and loads the response register, and returns to idle, where the
// next request is taken. The response register is separate, so a new request
// is taken while a result still waits; the commit waits only when the
// previous result has not been taken. During the sweep the block finds the
// addressed client, the lowest free slot and the lowest-distance entry among
// the other clients (ties to the lowest client id), which serves as the
// replacement when the preferred entry is deleted. Entry storage needs no
// clearing after reset: per-slot valid bits live in flops.
// Every response carries the preferred entry after the operation.
// ----------------------------------------------------------------------------
`include "best_route_source_table_unit_macros.svh"

module best_route_source_table_unit #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    brst_req_if.sink    req,
    brst_rsp_if.source  rsp
);
    import brst_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Control state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [TABLE_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic                   hit_reg, hit_next;
    logic                   free_reg, free_next;
    logic                   alt_reg, alt_next;
    logic                   best_present_reg, best_present_next;
    logic [15:0]            best_client_reg, best_client_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_data_reg, rsp_data_next;

    // Payload registers
    req_t                   cmd_reg, cmd_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    entry_t                 hit_ent_reg, hit_ent_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    entry_t                 alt_ent_reg, alt_ent_next;
    logic [7:0]             best_dist_reg, best_dist_next;
    logic [15:0]            best_group_reg, best_group_next;

    // Entry memory
    entry_t                 mem [TABLE_SLOTS];
    entry_t                 rd_data_reg;
    logic                   rd_issue;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    entry_t                 wr_data;

    // Sweep compare terms
    logic                   cur_valid;
    logic                   key_match;
    logic                   better;
    logic                   out_free;
    logic                   is_pref;
    logic                   status_bit;
    logic                   same_bit;

    // Handshake outputs
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Read side of the sweep
    assign rd_issue = (state_reg == ST_SCAN) && (rd_cnt_reg < CNT_W'(TABLE_SLOTS));
    assign rd_addr  = rd_cnt_reg[IDX_W-1:0];

    // Per-slot evaluation in the cycle after the read
    assign cur_valid = slot_valid_reg[cmp_idx_reg];
    assign key_match = (rd_data_reg.client == cmd_reg.client_id);
    assign better    = !alt_reg
                    || (rd_data_reg.distance < alt_ent_reg.distance)
                    || ((rd_data_reg.distance == alt_ent_reg.distance)
                        && (rd_data_reg.client < alt_ent_reg.client));

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign is_pref  = best_present_reg && (cmd_reg.client_id == best_client_reg);

    always_comb
    begin
        state_next        = state_reg;
        rd_cnt_next       = rd_cnt_reg;
        cmp_vld_next      = rd_issue;
        cmp_idx_next      = rd_addr;
        slot_valid_next   = slot_valid_reg;
        hit_next          = hit_reg;
        free_next         = free_reg;
        alt_next          = alt_reg;
        best_present_next = best_present_reg;
        best_client_next  = best_client_reg;
        best_dist_next    = best_dist_reg;
        best_group_next   = best_group_reg;
        rsp_valid_next    = rsp_valid_reg;
        rsp_data_next     = rsp_data_reg;
        cmd_next          = cmd_reg;
        hit_idx_next      = hit_idx_reg;
        hit_ent_next      = hit_ent_reg;
        free_idx_next     = free_idx_reg;
        alt_ent_next      = alt_ent_reg;
        wr_en             = 1'b0;
        wr_idx            = hit_idx_reg;
        wr_data           = '{client:   cmd_reg.client_id,
                              distance: cmd_reg.admin_distance,
                              group:    cmd_reg.next_hop_group};
        status_bit        = STATUS_OK;
        same_bit          = 1'b0;

        // Response drains independently of the table work
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.data;
                    rd_cnt_next = '0;
                    hit_next    = 1'b0;
                    free_next   = 1'b0;
                    alt_next    = 1'b0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (rd_issue)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    // Addressed client
                    if (cur_valid && key_match)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        hit_ent_next = rd_data_reg;
                    end
                    // Lowest free slot
                    if (!cur_valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                    // Best entry among the other clients
                    if (cur_valid && !key_match && better)
                    begin
                        alt_next     = 1'b1;
                        alt_ent_next = rd_data_reg;
                    end
                    if (cmp_idx_reg == IDX_W'(TABLE_SLOTS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    case (cmd_reg.operation)
                        OP_UPDATE:
                        begin
                            if (hit_reg || free_reg)
                            begin
                                wr_en  = 1'b1;
                                wr_idx = hit_reg ? hit_idx_reg : free_idx_reg;
                                slot_valid_next[wr_idx] = 1'b1;
                                // Sole entry, overwrite of preferred, or strictly lower
                                if (!alt_reg || is_pref
                                    || (cmd_reg.admin_distance < best_dist_reg))
                                begin
                                    best_present_next = 1'b1;
                                    best_client_next  = cmd_reg.client_id;
                                    best_dist_next    = cmd_reg.admin_distance;
                                    best_group_next   = cmd_reg.next_hop_group;
                                end
                            end
                            else
                            begin
                                status_bit = STATUS_FULL;
                            end
                        end

                        OP_DELETE:
                        begin
                            if (hit_reg)
                            begin
                                slot_valid_next[hit_idx_reg] = 1'b0;
                                if (is_pref)
                                begin
                                    best_present_next = alt_reg;
                                    best_client_next  = alt_reg ? alt_ent_reg.client : 16'd0;
                                    best_dist_next    = alt_ent_reg.distance;
                                    best_group_next   = alt_ent_reg.group;
                                end
                            end
                        end

                        OP_COMPARE:
                        begin
                            same_bit = hit_reg
                                    && (hit_ent_reg.distance == cmd_reg.admin_distance)
                                    && (hit_ent_reg.group == cmd_reg.next_hop_group);
                        end

                        default:
                        begin
                        end
                    endcase

                    // Result transaction
                    rsp_valid_next               = 1'b1;
                    rsp_data_next.status         = status_bit;
                    rsp_data_next.found          = hit_reg;
                    rsp_data_next.entry_distance = hit_reg ? hit_ent_reg.distance : 8'd0;
                    rsp_data_next.entry_group    = hit_reg ? hit_ent_reg.group : 16'd0;
                    rsp_data_next.same           = same_bit;
                    rsp_data_next.best_valid     = best_present_next;
                    rsp_data_next.best_client    = best_present_next ? best_client_next : 16'd0;
                    rsp_data_next.best_distance  = best_present_next ? best_dist_next : 8'd0;
                    rsp_data_next.best_group     = best_present_next ? best_group_next : 16'd0;
                    state_next                   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State machine, control state and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_cnt_reg       <= '0;
            cmp_vld_reg      <= 1'b0;
            slot_valid_reg   <= '0;
            hit_reg          <= 1'b0;
            free_reg         <= 1'b0;
            alt_reg          <= 1'b0;
            best_present_reg <= 1'b0;
            best_client_reg  <= 16'd0;
            rsp_valid_reg    <= 1'b0;
            rsp_data_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_cnt_reg       <= rd_cnt_next;
            cmp_vld_reg      <= cmp_vld_next;
            slot_valid_reg   <= slot_valid_next;
            hit_reg          <= hit_next;
            free_reg         <= free_next;
            alt_reg          <= alt_next;
            best_present_reg <= best_present_next;
            best_client_reg  <= best_client_next;
            rsp_valid_reg    <= rsp_valid_next;
            rsp_data_reg     <= rsp_data_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_ent_reg    <= hit_ent_next;
        free_idx_reg   <= free_idx_next;
        alt_ent_reg    <= alt_ent_next;
        best_dist_reg  <= best_dist_next;
        best_group_reg <= best_group_next;
    end

    // Entry memory: one write port, one registered read port.
    // Reads happen only while sweeping and writes only at commit, so they never overlap.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Assertions
    `BRST_ASSERT_HOLDS(a_pref_tracks_table, clk, rst_n, 1'b1,
        best_present_reg == (|slot_valid_reg),
        "preferred entry state disagrees with table occupancy")

    `BRST_ASSERT_HOLDS(a_full_only_when_full, clk, rst_n,
        rsp_valid_reg && (rsp_data_reg.status == STATUS_FULL),
        (&slot_valid_reg) && !rsp_data_reg.found,
        "table full reported while a slot was free or the client was present")

    `BRST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready,
        !req.ready && (state_reg == ST_SCAN),
        "request taken while a table sweep was in progress")

endmodule
